@@ rtl/nibble_dfa_pattern_scanner_assert.svh @@
// Assertion macros for the nibble automaton scanner.
// No dependencies; included by the top level.
`ifndef NIBBLE_DFA_PATTERN_SCANNER_ASSERT_SVH
`define NIBBLE_DFA_PATTERN_SCANNER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define NDPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scanner assertion failed");

// Check that cons holds in the cycle after ante.
`define NDPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scanner assertion failed");

`endif

@@ rtl/ndps_pkg.sv @@
// Shared constants, command codes and types of the nibble automaton scanner.
// No dependencies.
package ndps_pkg;

    localparam int NUM_NODES       = 1024;
    localparam int SYMBOL_COUNT    = 256;
    localparam int MAX_MATCH_CHAIN = 64;
    localparam int NIB_SLOTS       = 16;

    localparam int NODE_W  = 10;
    localparam int SYM_W   = 8;
    localparam int OFS_W   = 16;
    localparam int POS_W   = 32;
    localparam int CMD_W   = 3;
    localparam int NIB_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = $clog2(MAX_MATCH_CHAIN + 1);

    localparam int TRANS_DEPTH = NUM_NODES * NIB_SLOTS;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_WR_TRANS = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WR_NODE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WR_OFS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

    // Node table entry
    typedef struct packed {
        logic              flag;
        logic [SYM_W-1:0]  sym;
        logic [NODE_W-1:0] next;
    } t_node;

    // One reported match
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_result;

endpackage

@@ rtl/ndps_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ndps_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/ndps_out_reg.sv @@
// Output register for match results with valid/ready on the far side.
// Depends on ndps_pkg.
module ndps_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ndps_pkg::t_result i_data,
    output logic             o_free,
    output logic             o_valid,
    input  logic             i_ready,
    output ndps_pkg::t_result o_data
);

    logic r_valid;
    ndps_pkg::t_result r_data;

    // Slot can take a new result when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Hold valid until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Load payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

endmodule

@@ rtl/nibble_dfa_pattern_scanner.sv @@
// Top level of the nibble automaton scanner: control sequencer and table RAMs.
// Depends on ndps_pkg, ndps_ram, ndps_out_reg and the assertion header.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  input    | i_valid / o_ready          | i_cmd, i_node_id, i_nibble, ... bytes
//  result   | o_valid / i_ready          | o_symbol_id, o_match_position, o_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_data (start node)
//
// Loading commands complete on acceptance. A scan byte makes two dependent reads
// of the transition RAM, high nibble then low nibble, and each reported match
// node adds a node RAM read then an offset RAM read; end of stream walks the
// match chain the same way and then returns to the start node.
// Reset clears the sequencer, current node, byte count and start node; the
// tables are not cleared. A stalled result channel holds the chain walk.
`include "nibble_dfa_pattern_scanner_assert.svh"

module nibble_dfa_pattern_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_cmd,
    input  logic [9:0]  i_node_id,
    input  logic [3:0]  i_nibble,
    input  logic [9:0]  i_target_node,
    input  logic        i_is_match,
    input  logic [7:0]  i_symbol_sel,
    input  logic [15:0] i_offset_value,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_symbol_id,
    output logic [31:0] o_match_position,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [9:0]  i_cfg_data
);

    localparam int TA_W = $clog2(ndps_pkg::TRANS_DEPTH);
    localparam int NA_W = $clog2(ndps_pkg::NUM_NODES);
    localparam int SA_W = $clog2(ndps_pkg::SYMBOL_COUNT);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHAIN,
        S_OFS,
        S_LO
    } t_state;

    t_state r_state, n_state;
    logic [ndps_pkg::NODE_W-1:0] r_cur, n_cur;
    logic [ndps_pkg::NODE_W-1:0] r_start;
    logic [ndps_pkg::POS_W-1:0]  r_bytes, n_bytes;
    logic [ndps_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [ndps_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [ndps_pkg::NIB_W-1:0]  r_hi, n_hi;
    logic [ndps_pkg::NIB_W-1:0]  r_lo, n_lo;
    logic                        r_pend_v, n_pend_v;
    logic [ndps_pkg::SYM_W-1:0]  r_pend_sym, n_pend_sym;
    logic [ndps_pkg::POS_W-1:0]  r_pend_pos, n_pend_pos;

    logic                        accept;
    logic                        is_m;
    logic [ndps_pkg::NODE_W-1:0] eff_cur;

    logic                        trans_we;
    logic [TA_W-1:0]             trans_raddr;
    logic [ndps_pkg::NODE_W-1:0] trans_q;
    logic                        node_we;
    logic [NA_W-1:0]             node_raddr;
    ndps_pkg::t_node             node_q;
    ndps_pkg::t_node             node_wdata;
    logic                        ofs_we;
    logic [SA_W-1:0]             ofs_raddr;
    logic [ndps_pkg::OFS_W-1:0]  ofs_q;

    logic                        push;
    logic                        push_last;
    logic                        out_free;
    ndps_pkg::t_result           push_data;
    ndps_pkg::t_result           out_data;

    // Table memories
    ndps_ram #(
        .DEPTH(ndps_pkg::TRANS_DEPTH),
        .WIDTH(ndps_pkg::NODE_W)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (trans_we),
        .i_waddr ({i_node_id, i_nibble}),
        .i_wdata (i_target_node),
        .i_raddr (trans_raddr),
        .o_rdata (trans_q)
    );

    assign node_wdata = '{flag: i_is_match, sym: i_symbol_sel, next: i_target_node};

    ndps_ram #(
        .DEPTH(ndps_pkg::NUM_NODES),
        .WIDTH($bits(ndps_pkg::t_node))
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (i_node_id),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_q)
    );

    ndps_ram #(
        .DEPTH(ndps_pkg::SYMBOL_COUNT),
        .WIDTH(ndps_pkg::OFS_W)
    ) u_ofs_ram (
        .i_clk   (i_clk),
        .i_we    (ofs_we),
        .i_waddr (i_symbol_sel),
        .i_wdata (i_offset_value),
        .i_raddr (ofs_raddr),
        .o_rdata (ofs_q)
    );

    // Result register
    assign push_data = '{sym: r_pend_sym, pos: r_pend_pos, last: push_last};

    ndps_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_symbol_id      = out_data.sym;
    assign o_match_position = out_data.pos;
    assign o_last           = out_data.last;

    // Handshakes: new items in idle or during the low-nibble writeback
    assign o_ready     = (r_state == S_IDLE) || (r_state == S_LO);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // Forward the low-nibble result as current node while it is written back
    assign eff_cur = (r_state == S_LO) ? trans_q : r_cur;
    assign is_m    = node_q.flag && (r_cnt < ndps_pkg::CNT_W'(ndps_pkg::MAX_MATCH_CHAIN));

    // Sequencer next state, RAM addressing and result push
    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_bytes     = r_bytes;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_pend_v    = r_pend_v;
        n_pend_sym  = r_pend_sym;
        n_pend_pos  = r_pend_pos;
        node_raddr  = r_cur;
        trans_raddr = {r_cur, r_hi};
        ofs_raddr   = node_q.sym;
        trans_we    = 1'b0;
        node_we     = 1'b0;
        ofs_we      = 1'b0;
        push        = 1'b0;
        push_last   = 1'b0;

        unique case (r_state)
            S_IDLE, S_LO: begin
                // Finish the byte step, then launch reads for a new item
                if (r_state == S_LO) begin
                    n_cur   = trans_q;
                    n_bytes = r_bytes + 32'd1;
                end
                n_state     = S_IDLE;
                node_raddr  = eff_cur;
                trans_raddr = {eff_cur, i_data_byte[7:4]};
                if (accept) begin
                    n_cmd = i_cmd;
                    n_hi  = i_data_byte[7:4];
                    n_lo  = i_data_byte[3:0];
                    n_cnt = '0;
                    unique case (i_cmd)
                        ndps_pkg::CMD_WR_TRANS: trans_we = 1'b1;
                        ndps_pkg::CMD_WR_NODE:  node_we  = 1'b1;
                        ndps_pkg::CMD_WR_OFS:   ofs_we   = 1'b1;
                        ndps_pkg::CMD_SCAN,
                        ndps_pkg::CMD_END:      n_state  = S_CHAIN;
                        default: ;
                    endcase
                end
            end
            S_CHAIN: begin
                // Hold while a pending result cannot leave
                if (!(r_pend_v && !out_free)) begin
                    if (r_pend_v) begin
                        push      = 1'b1;
                        push_last = !is_m;
                        n_pend_v  = 1'b0;
                    end
                    if (is_m) begin
                        ofs_raddr  = node_q.sym;
                        n_pend_sym = node_q.sym;
                        n_state    = S_OFS;
                    end else if (r_cmd == ndps_pkg::CMD_SCAN) begin
                        trans_raddr = {trans_q, r_lo};
                        n_state     = S_LO;
                    end else begin
                        n_cur   = r_start;
                        n_bytes = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            S_OFS: begin
                // Form the position and advance along the chain
                n_pend_pos  = r_bytes - {16'd0, ofs_q};
                n_pend_v    = 1'b1;
                n_cnt       = r_cnt + ndps_pkg::CNT_W'(1);
                n_cur       = node_q.next;
                node_raddr  = node_q.next;
                trans_raddr = {node_q.next, r_hi};
                n_state     = S_CHAIN;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_bytes  <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_start  <= '0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_bytes  <= n_bytes;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
        end
        r_cmd      <= n_cmd;
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_pend_sym <= n_pend_sym;
        r_pend_pos <= n_pend_pos;
    end

    // Checks
    `NDPS_ASSERT_SAME(a_chain_limit, i_clk, i_rst_n, r_state == S_OFS,
        r_cnt < ndps_pkg::CNT_W'(ndps_pkg::MAX_MATCH_CHAIN))
    `NDPS_ASSERT_SAME(a_no_pending_on_accept, i_clk, i_rst_n, o_ready, !r_pend_v)
    `NDPS_ASSERT_NEXT(a_pending_after_ofs, i_clk, i_rst_n, r_state == S_OFS,
        r_pend_v && r_state == S_CHAIN)

endmodule

@@ bench/match_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the nibble automaton scanner: keeps its own copy of the tables,
// predicts the matches of each command transaction and checks the result channel.
// Depends on ndps_pkg only.
module match_checker
    import ndps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [NODE_W-1:0] i_node_id,
    input  logic [NIB_W-1:0]  i_nibble,
    input  logic [NODE_W-1:0] i_target_node,
    input  logic              i_is_match,
    input  logic [SYM_W-1:0]  i_symbol_sel,
    input  logic [OFS_W-1:0]  i_offset_value,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_res_valid,
    input  logic              i_res_ready,
    input  logic [SYM_W-1:0]  i_symbol_id,
    input  logic [POS_W-1:0]  i_match_position,
    input  logic              i_last,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [NODE_W-1:0] i_cfg_data,
    output int                o_mismatches,
    output int                o_pending
);

    logic [NODE_W-1:0] trans_tab [TRANS_DEPTH];
    t_node             node_tab  [NUM_NODES];
    logic [OFS_W-1:0]  ofs_tab   [SYMBOL_COUNT];
    logic [NODE_W-1:0] cur_node;
    logic [NODE_W-1:0] start_node;
    logic [POS_W-1:0]  consumed;
    t_result           expected_matches [$];
    int                mismatches = 0;

    assign o_mismatches = mismatches;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] scanner mismatch: %s", $time, what);
    endtask

    // Walk the match nodes from the current node, one match each, cut at the limit
    task automatic queue_chain_matches();
        int      hops = 0;
        t_result m;
        while (hops < MAX_MATCH_CHAIN && node_tab[cur_node].flag) begin
            m.sym  = node_tab[cur_node].sym;
            m.pos  = consumed - POS_W'(ofs_tab[m.sym]);
            m.last = 1'b0;
            expected_matches.push_back(m);
            cur_node = node_tab[cur_node].next;
            hops++;
        end
        // mark the final match of this command
        if (hops > 0) begin
            m = expected_matches.pop_back();
            m.last = 1'b1;
            expected_matches.push_back(m);
        end
    endtask

    // Apply one accepted command to the table copy and the automaton state
    task automatic step_automaton();
        case (i_cmd)
            CMD_WR_TRANS: trans_tab[{i_node_id, i_nibble}] = i_target_node;
            CMD_WR_NODE: begin
                node_tab[i_node_id] = '{flag: i_is_match, sym: i_symbol_sel,
                                        next: i_target_node};
            end
            CMD_WR_OFS: ofs_tab[i_symbol_sel] = i_offset_value;
            CMD_SCAN: begin
                queue_chain_matches();
                // high nibble first; the node in between never reports
                cur_node = trans_tab[{cur_node, i_data_byte[7:4]}];
                cur_node = trans_tab[{cur_node, i_data_byte[3:0]}];
                consumed = consumed + 1'b1;
            end
            CMD_END: begin
                queue_chain_matches();
                cur_node = start_node;
                consumed = '0;
            end
            default: ;
        endcase
    endtask

    // Compare one result transaction with the oldest expected match
    task automatic check_match();
        t_result want;
        if (expected_matches.size() == 0) begin
            report_mismatch($sformatf("unexpected match symbol %0d position 0x%08h last %0b",
                                      i_symbol_id, i_match_position, i_last));
        end else begin
            want = expected_matches.pop_front();
            if (i_symbol_id !== want.sym)
                report_mismatch($sformatf("symbol_id %0d, expected %0d",
                                          i_symbol_id, want.sym));
            if (i_match_position !== want.pos)
                report_mismatch($sformatf("match_position 0x%08h, expected 0x%08h",
                                          i_match_position, want.pos));
            if (i_last !== want.last)
                report_mismatch($sformatf("last %0b, expected %0b", i_last, want.last));
        end
    endtask

    // Sample all three channels on the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_node   = '0;
            start_node = '0;
            consumed   = '0;
            expected_matches.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                start_node = i_cfg_data;
            if (i_res_valid && i_res_ready)
                check_match();
            if (i_in_valid && i_in_ready)
                step_automaton();
        end
        o_pending <= expected_matches.size();
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the scanner testbench: clock, reset, command and start-node stimulus,
// result back-pressure and the verdict. Depends on ndps_pkg, the scanner and match_checker.
module tb_top;
    import ndps_pkg::*;

    localparam int WORK_NODES   = 5;
    localparam int SYM_SET_SIZE = 6;
    localparam int PHASES       = 4;
    localparam int PHASE_ITEMS  = 50;
    localparam int DRAIN_CYCLES = 16;
    localparam int STUCK_LIMIT  = 2000;

    // command codes the block ignores
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [NODE_W-1:0] node_id;
        logic [NIB_W-1:0]  nib;
        logic [NODE_W-1:0] target;
        logic              is_match;
        logic [SYM_W-1:0]  sym;
        logic [OFS_W-1:0]  ofs;
        logic [BYTE_W-1:0] data;
    } t_scan_cmd;

    logic              i_clk;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              o_ready;
    logic [CMD_W-1:0]  i_cmd            = '0;
    logic [NODE_W-1:0] i_node_id        = '0;
    logic [NIB_W-1:0]  i_nibble         = '0;
    logic [NODE_W-1:0] i_target_node    = '0;
    logic              i_is_match       = 1'b0;
    logic [SYM_W-1:0]  i_symbol_sel     = '0;
    logic [OFS_W-1:0]  i_offset_value   = '0;
    logic [BYTE_W-1:0] i_data_byte      = '0;
    logic              o_valid;
    logic              i_ready          = 1'b0;
    logic [SYM_W-1:0]  o_symbol_id;
    logic [POS_W-1:0]  o_match_position;
    logic              o_last;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic [NODE_W-1:0] i_cfg_data       = '0;

    int                fail_count;
    int                pending;
    bit                quiet = 1'b0;

    // nodes whose entries are all written, and symbols whose offsets are written
    logic [NODE_W-1:0] work_node [WORK_NODES];
    logic [SYM_W-1:0]  sym_set   [SYM_SET_SIZE];

    nibble_dfa_pattern_scanner dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cmd            (i_cmd),
        .i_node_id        (i_node_id),
        .i_nibble         (i_nibble),
        .i_target_node    (i_target_node),
        .i_is_match       (i_is_match),
        .i_symbol_sel     (i_symbol_sel),
        .i_offset_value   (i_offset_value),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_symbol_id      (o_symbol_id),
        .o_match_position (o_match_position),
        .o_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    match_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_cmd            (i_cmd),
        .i_node_id        (i_node_id),
        .i_nibble         (i_nibble),
        .i_target_node    (i_target_node),
        .i_is_match       (i_is_match),
        .i_symbol_sel     (i_symbol_sel),
        .i_offset_value   (i_offset_value),
        .i_data_byte      (i_data_byte),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_symbol_id      (o_symbol_id),
        .i_match_position (o_match_position),
        .i_last           (o_last),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (fail_count),
        .o_pending        (pending)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    function automatic logic [NODE_W-1:0] pick_work();
        return work_node[$urandom_range(0, WORK_NODES - 1)];
    endfunction

    function automatic logic [SYM_W-1:0] pick_sym();
        return sym_set[$urandom_range(0, SYM_SET_SIZE - 1)];
    endfunction

    function automatic bit in_work(input logic [NODE_W-1:0] node);
        foreach (work_node[k])
            if (work_node[k] == node)
                return 1'b1;
        return 1'b0;
    endfunction

    // Random content in every field; callers override what matters
    function automatic t_scan_cmd noise_cmd();
        t_scan_cmd it;
        it.cmd      = CMD_W'($urandom);
        it.node_id  = NODE_W'($urandom);
        it.nib      = NIB_W'($urandom);
        it.target   = NODE_W'($urandom);
        it.is_match = 1'($urandom);
        it.sym      = SYM_W'($urandom);
        it.ofs      = OFS_W'($urandom);
        it.data     = BYTE_W'($urandom);
        return it;
    endfunction

    // Mostly scans; table writes keep the working nodes closed among themselves
    function automatic t_scan_cmd random_item();
        t_scan_cmd it   = noise_cmd();
        int        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            it.cmd = CMD_SCAN;
        end else if (roll < 63) begin
            it.cmd = CMD_END;
        end else if (roll < 75) begin
            it.cmd = CMD_WR_TRANS;
            if ($urandom_range(0, 2) != 0)
                it.node_id = pick_work();
            if (in_work(it.node_id))
                it.target = pick_work();
        end else if (roll < 87) begin
            it.cmd = CMD_WR_NODE;
            if ($urandom_range(0, 2) != 0) begin
                it.node_id  = pick_work();
                it.is_match = ($urandom_range(0, 2) == 0);
            end
            if (in_work(it.node_id)) begin
                it.sym    = pick_sym();
                it.target = pick_work();
            end
        end else if (roll < 96) begin
            it.cmd = CMD_WR_OFS;
            if ($urandom_range(0, 1) != 0)
                it.sym = pick_sym();
        end else begin
            it.cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        end
        return it;
    endfunction

    // Drive one command transaction, with an optional idle burst ahead of it
    task automatic issue(input t_scan_cmd it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= it.cmd;
        i_node_id      <= it.node_id;
        i_nibble       <= it.nib;
        i_target_node  <= it.target;
        i_is_match     <= it.is_match;
        i_symbol_sel   <= it.sym;
        i_offset_value <= it.ofs;
        i_data_byte    <= it.data;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic wr_trans(input logic [NODE_W-1:0] node, input logic [NIB_W-1:0] nib,
                            input logic [NODE_W-1:0] tgt);
        t_scan_cmd it = noise_cmd();
        it.cmd     = CMD_WR_TRANS;
        it.node_id = node;
        it.nib     = nib;
        it.target  = tgt;
        issue(it);
    endtask

    task automatic wr_node(input logic [NODE_W-1:0] node, input logic match,
                           input logic [SYM_W-1:0] sym, input logic [NODE_W-1:0] nxt);
        t_scan_cmd it = noise_cmd();
        it.cmd      = CMD_WR_NODE;
        it.node_id  = node;
        it.is_match = match;
        it.sym      = sym;
        it.target   = nxt;
        issue(it);
    endtask

    task automatic wr_ofs(input logic [SYM_W-1:0] sym, input logic [OFS_W-1:0] ofs);
        t_scan_cmd it = noise_cmd();
        it.cmd = CMD_WR_OFS;
        it.sym = sym;
        it.ofs = ofs;
        issue(it);
    endtask

    task automatic scan(input logic [BYTE_W-1:0] data);
        t_scan_cmd it = noise_cmd();
        it.cmd  = CMD_SCAN;
        it.data = data;
        issue(it);
    endtask

    task automatic end_stream();
        t_scan_cmd it = noise_cmd();
        it.cmd = CMD_END;
        issue(it);
    endtask

    // Wait for every expected match, then let a match-free command finish
    task automatic settle();
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_start(input logic [NODE_W-1:0] node);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= node;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Result back-pressure: random stall bursts between calm stretches
    initial begin : result_stall
        forever begin
            @(posedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(0, 30)) @(posedge i_clk);
        end
    end

    // Abort when no channel moves a transaction for too long
    initial begin : watchdog
        int stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        t_scan_cmd         it;
        int                counted;
        logic [NODE_W-1:0] start_sel;

        work_node[0] = '0;
        work_node[1] = '1;
        for (int k = 2; k < WORK_NODES; k++)
            work_node[k] = NODE_W'($urandom);
        sym_set[0] = '0;
        sym_set[1] = '1;
        for (int k = 2; k < SYM_SET_SIZE; k++)
            sym_set[k] = SYM_W'($urandom);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load the working nodes: transitional kind and all 16 transitions each
        foreach (work_node[k]) begin
            wr_node(work_node[k], 1'b0, pick_sym(), pick_work());
            for (int nib = 0; nib < NIB_SLOTS; nib++)
                wr_trans(work_node[k], NIB_W'(nib), pick_work());
        end
        foreach (sym_set[k])
            wr_ofs(sym_set[k], OFS_W'($urandom));

        // byte extremes with no match nodes anywhere
        scan(8'h00);
        scan(8'hFF);
        scan(8'hA5);
        end_stream();
        // self-looping match node at the start: chain cut at the limit on end
        // of stream and on a scan, position wrapping below zero
        wr_node('0, 1'b1, '0, '0);
        wr_ofs('0, '1);
        end_stream();
        scan(8'h3C);
        // single match, then a match node reached between the two nibbles
        wr_node('0, 1'b1, '1, '1);
        wr_ofs('1, '0);
        wr_trans('1, 4'h5, '0);
        end_stream();
        scan(8'h5A);
        scan(8'h00);
        // ignored command codes
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++) begin
            it     = noise_cmd();
            it.cmd = CMD_W'(c);
            issue(it);
        end
        // two-node match loop, then drop the start node back to transitional
        wr_node('1, 1'b1, pick_sym(), '0);
        end_stream();
        scan(8'hC3);
        wr_node('0, 1'b0, pick_sym(), pick_work());
        end_stream();
        i_valid <= 1'b0;

        // random phases, each under its own start node; the last one without idling
        for (int ph = 0; ph < PHASES; ph++) begin
            settle();
            quiet <= (ph == PHASES - 1);
            if (ph == 0)
                start_sel = '1;
            else if (ph == 2)
                start_sel = '0;
            else
                start_sel = pick_work();
            write_start(start_sel);
            end_stream();
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                it = random_item();
                issue(it);
                if (it.cmd < CMD_RSVD_FIRST)
                    counted++;
            end
            i_valid <= 1'b0;
        end

        settle();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
